@@ rtl/kct_pkg.sv @@
// ----------------------------------------------------------------------------
// kct_pkg: shared types and codes of the key confirmation tracker
// Command, state and status codes, field widths and the request / result
// beats used by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package kct_pkg;

    // Field widths
    localparam int CMD_W     = 3;
    localparam int NODE_ID_W = 4;
    localparam int STATE_W   = 2;
    localparam int RETRY_W   = 8;
    localparam int NONCE_W   = 64;
    localparam int STATUS_W  = 3;
    localparam int MASK_W    = 16;
    localparam int COUNT_W   = 5;

    // Table sizing
    localparam int MAX_NODES_DEFAULT = 16;
    localparam int DEFAULT_NODES     = 10;
    // node_id reaches this many entries at most
    localparam int ID_SPAN           = 1 << NODE_ID_W;

    localparam logic [RETRY_W-1:0] MAX_RETRY_RESET = 8'd3;

    // Commands
    localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MARK     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESPONSE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SWEEP    = 3'd5;

    // Confirmation states
    localparam logic [STATE_W-1:0] ST_INITIAL  = 2'd0;
    localparam logic [STATE_W-1:0] ST_WAITING  = 2'd1;
    localparam logic [STATE_W-1:0] ST_RECEIVED = 2'd2;
    localparam logic [STATE_W-1:0] ST_RESENT   = 2'd3;

    // Result status
    localparam logic [STATUS_W-1:0] STAT_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_AWAITING = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_TAG_REJECTED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_REPLAY       = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [NODE_ID_W-1:0] node_id;
        logic [STATE_W-1:0]   new_state;
        logic                 tag_valid;
        logic [NONCE_W-1:0]   nonce_count;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                entry_present;
        logic [STATE_W-1:0]  entry_state;
        logic [RETRY_W-1:0]  retry_count;
        logic [MASK_W-1:0]   resend_mask;
        logic                just_committed;
        logic [COUNT_W-1:0]  node_count;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;
        logic exec;
        logic sweep;
        logic check;
        logic check_last;
        logic report;
        logic use_idx;
    } ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_sweep;
        logic enter_check;
    } dp_status_t;

endpackage

@@ rtl/key_confirmation_tracker_core.sv @@
// ----------------------------------------------------------------------------
// key_confirmation_tracker_core: node key confirmation tracker
// Per-node confirmation table with add, remove, set state, mark sent,
// response and timeout sweep commands and a sticky all-confirmed commit.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Its result beat is
// shown on result for exactly one cycle, marked by done, and must be taken
// then: there is no way to hold it off. Add, remove, set state, mark sent,
// rejected responses, responses accepted once the commit bit is set and
// unused command codes step from acceptance through execute and report
// back to idle, with done high in the first idle cycle. A timeout sweep,
// and an accepted response while not yet committed, walk the node table
// through its single access port, one entry a cycle, between execute and
// report; the walk covers D entries, where D is MAX_NODES capped at the 16
// entries that node_id can reach. The retry limit is written on the cfg
// channel, which is always ready; write it only while busy is low.
// ----------------------------------------------------------------------------
module key_confirmation_tracker_core #(
    parameter int MAX_NODES = kct_pkg::MAX_NODES_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  kct_pkg::request_t           request,
    output logic                        done,
    output kct_pkg::result_t            result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [kct_pkg::RETRY_W-1:0] cfg_data
);

    // Entries past the node_id range can never be present
    localparam int TABLE_DEPTH = (MAX_NODES < kct_pkg::ID_SPAN) ?
                                 MAX_NODES : kct_pkg::ID_SPAN;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    kct_pkg::ctrl_t      ctrl;
    kct_pkg::dp_status_t dp_status;
    logic [IDX_W-1:0]    idx;
    logic                start_ok;

    assign cfg_ready = 1'b1;
    assign start_ok  = start && !busy;

    kct_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_ok),
        .busy      (busy),
        .dp_status (dp_status),
        .ctrl      (ctrl),
        .idx       (idx)
    );

    kct_datapath #(
        .MAX_NODES   (MAX_NODES),
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .ctrl      (ctrl),
        .idx       (idx),
        .dp_status (dp_status),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .result    (result),
        .done      (done)
    );

endmodule

@@ rtl/kct_ctrl.sv @@
// ----------------------------------------------------------------------------
// kct_ctrl: sequencer of the key confirmation tracker
// Steps each command through execute, an optional table walk (timeout sweep
// or all-confirmed check) and the result report.
// ----------------------------------------------------------------------------
module kct_ctrl #(
    parameter int TABLE_DEPTH = kct_pkg::MAX_NODES_DEFAULT,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  kct_pkg::dp_status_t dp_status,
    output kct_pkg::ctrl_t      ctrl,
    output logic [IDX_W-1:0]    idx
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SWEEP  = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_REPORT = 3'd4;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             idx_last;

    assign idx_last = (idx_reg == IDX_LAST);
    assign idx      = idx_reg;
    assign busy     = (state_reg != S_IDLE);

    // Decode state into datapath commands and next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ctrl       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctrl.latch = start;
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctrl.exec = 1'b1;
                idx_next  = '0;
                if (dp_status.is_sweep)
                begin
                    state_next = S_SWEEP;
                end
                else if (dp_status.enter_check)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_REPORT;
                end
            end
            S_SWEEP:
            begin
                ctrl.sweep   = 1'b1;
                ctrl.use_idx = 1'b1;
                idx_next     = IDX_W'(idx_reg + 1'b1);
                if (idx_last)
                begin
                    state_next = S_REPORT;
                end
            end
            S_CHECK:
            begin
                ctrl.check      = 1'b1;
                ctrl.check_last = idx_last;
                ctrl.use_idx    = 1'b1;
                idx_next        = IDX_W'(idx_reg + 1'b1);
                if (idx_last)
                begin
                    state_next = S_REPORT;
                end
            end
            S_REPORT:
            begin
                ctrl.report = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and walk index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

@@ rtl/kct_datapath.sv @@
// ----------------------------------------------------------------------------
// kct_datapath: node table and result logic of the key confirmation tracker
// Holds the node table, the retry limit, the node count and the commit bit,
// and applies one table access per cycle at the address the sequencer picks.
// ----------------------------------------------------------------------------
module kct_datapath #(
    parameter int MAX_NODES   = kct_pkg::MAX_NODES_DEFAULT,
    parameter int TABLE_DEPTH = kct_pkg::MAX_NODES_DEFAULT,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kct_pkg::request_t             request,
    input  kct_pkg::ctrl_t                ctrl,
    input  logic [IDX_W-1:0]              idx,
    output kct_pkg::dp_status_t           dp_status,
    input  logic                          cfg_write,
    input  logic [kct_pkg::RETRY_W-1:0]   cfg_data,
    output kct_pkg::result_t              result,
    output logic                          done
);

    // Nodes 1 to DEFAULT_NODES start present, where the table reaches them
    localparam int COUNT_RESET = (MAX_NODES - 1 < kct_pkg::DEFAULT_NODES) ?
                                 (MAX_NODES - 1) : kct_pkg::DEFAULT_NODES;

    // Node table
    logic                          present_reg [TABLE_DEPTH];
    logic [kct_pkg::STATE_W-1:0]   state_reg   [TABLE_DEPTH];
    logic [kct_pkg::RETRY_W-1:0]   retries_reg [TABLE_DEPTH];
    logic [kct_pkg::NONCE_W-1:0]   nonce_reg   [TABLE_DEPTH];

    kct_pkg::request_t             req_reg;
    logic [kct_pkg::RETRY_W-1:0]   max_retry_reg;
    logic [kct_pkg::COUNT_W-1:0]   count_reg;
    logic [kct_pkg::COUNT_W-1:0]   count_next;
    logic                          committed_reg;
    logic                          committed_next;
    logic                          pulse_reg;
    logic                          pulse_next;
    logic                          allconf_reg;
    logic                          allconf_next;
    logic [kct_pkg::STATUS_W-1:0]  status_reg;
    logic [kct_pkg::STATUS_W-1:0]  status_next;
    logic [kct_pkg::MASK_W-1:0]    mask_reg;
    logic [kct_pkg::MASK_W-1:0]    mask_next;
    kct_pkg::result_t              result_reg;
    logic                          done_reg;

    logic [IDX_W-1:0]              addr;
    logic                          in_range;
    logic                          rd_present;
    logic [kct_pkg::STATE_W-1:0]   rd_state;
    logic [kct_pkg::RETRY_W-1:0]   rd_retries;
    logic [kct_pkg::NONCE_W-1:0]   rd_nonce;
    logic                          rd_awaiting;
    logic                          hit;

    logic                          wr_en;
    logic                          wr_present;
    logic [kct_pkg::STATE_W-1:0]   wr_state;
    logic [kct_pkg::RETRY_W-1:0]   wr_retries;
    logic [kct_pkg::NONCE_W-1:0]   wr_nonce;
    logic                          resp_accept;

    // Select the one table address of this cycle
    assign in_range = (32'(req_reg.node_id) < MAX_NODES);
    assign addr     = ctrl.use_idx ? idx : req_reg.node_id[IDX_W-1:0];

    assign rd_present  = present_reg[addr];
    assign rd_state    = state_reg[addr];
    assign rd_retries  = retries_reg[addr];
    assign rd_nonce    = nonce_reg[addr];
    assign rd_awaiting = (rd_state == kct_pkg::ST_WAITING) ||
                         (rd_state == kct_pkg::ST_RESENT);
    assign hit         = in_range && rd_present;

    assign dp_status.is_sweep    = (req_reg.command == kct_pkg::CMD_SWEEP);
    assign dp_status.enter_check = resp_accept && !committed_reg;

    // Work out table write and bookkeeping for this cycle
    always_comb
    begin
        wr_en          = 1'b0;
        wr_present     = rd_present;
        wr_state       = rd_state;
        wr_retries     = rd_retries;
        wr_nonce       = rd_nonce;
        resp_accept    = 1'b0;
        status_next    = status_reg;
        mask_next      = mask_reg;
        count_next     = count_reg;
        allconf_next   = allconf_reg;
        committed_next = committed_reg;
        pulse_next     = pulse_reg;
        if (ctrl.latch)
        begin
            status_next  = kct_pkg::STAT_OK;
            mask_next    = '0;
            pulse_next   = 1'b0;
            allconf_next = 1'b1;
        end
        else if (ctrl.exec)
        begin
            unique case (req_reg.command)
                kct_pkg::CMD_ADD, kct_pkg::CMD_REMOVE:
                begin
                    if (!in_range)
                    begin
                        status_next = kct_pkg::STAT_NOT_FOUND;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_present = (req_reg.command == kct_pkg::CMD_ADD);
                        wr_state   = kct_pkg::ST_INITIAL;
                        wr_retries = '0;
                        wr_nonce   = '0;
                        if (req_reg.command == kct_pkg::CMD_ADD)
                        begin
                            count_next = rd_present ? count_reg :
                                         kct_pkg::COUNT_W'(count_reg + 1'b1);
                        end
                        else
                        begin
                            count_next = rd_present ?
                                         kct_pkg::COUNT_W'(count_reg - 1'b1) : count_reg;
                        end
                    end
                end
                kct_pkg::CMD_SET, kct_pkg::CMD_MARK:
                begin
                    if (!hit)
                    begin
                        status_next = kct_pkg::STAT_NOT_FOUND;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        wr_state = (req_reg.command == kct_pkg::CMD_SET) ?
                                   req_reg.new_state : kct_pkg::ST_WAITING;
                    end
                end
                kct_pkg::CMD_RESPONSE:
                begin
                    // Reject in order: absent, not awaiting, bad tag, stale nonce
                    priority if (!hit)
                    begin
                        status_next = kct_pkg::STAT_NOT_FOUND;
                    end
                    else if (!rd_awaiting)
                    begin
                        status_next = kct_pkg::STAT_NOT_AWAITING;
                    end
                    else if (!req_reg.tag_valid)
                    begin
                        status_next = kct_pkg::STAT_TAG_REJECTED;
                    end
                    else if (req_reg.nonce_count <= rd_nonce)
                    begin
                        status_next = kct_pkg::STAT_REPLAY;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_state    = kct_pkg::ST_RECEIVED;
                        wr_nonce    = req_reg.nonce_count;
                        resp_accept = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (ctrl.sweep)
        begin
            // Advance retries of awaiting nodes below the limit
            if (rd_present && rd_awaiting && (rd_retries < max_retry_reg))
            begin
                wr_en      = 1'b1;
                wr_retries = kct_pkg::RETRY_W'(rd_retries + 1'b1);
                wr_state   = kct_pkg::ST_RESENT;
                mask_next  = mask_reg | (kct_pkg::MASK_W'(1) << idx);
            end
        end
        else if (ctrl.check)
        begin
            // Drop the all-confirmed flag on any present, unconfirmed node
            allconf_next = allconf_reg &&
                           !(rd_present && (rd_state != kct_pkg::ST_RECEIVED));
            if (ctrl.check_last && allconf_next)
            begin
                committed_next = 1'b1;
                pulse_next     = 1'b1;
            end
        end
    end

    // Node table storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                present_reg[i] <= (i >= 1) && (i <= kct_pkg::DEFAULT_NODES);
                state_reg[i]   <= kct_pkg::ST_INITIAL;
                retries_reg[i] <= '0;
                nonce_reg[i]   <= '0;
            end
        end
        else if (wr_en)
        begin
            present_reg[addr] <= wr_present;
            state_reg[addr]   <= wr_state;
            retries_reg[addr] <= wr_retries;
            nonce_reg[addr]   <= wr_nonce;
        end
    end

    // Bookkeeping registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_retry_reg <= kct_pkg::MAX_RETRY_RESET;
            count_reg     <= kct_pkg::COUNT_W'(COUNT_RESET);
            committed_reg <= 1'b0;
            pulse_reg     <= 1'b0;
            allconf_reg   <= 1'b1;
            status_reg    <= kct_pkg::STAT_OK;
            mask_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                max_retry_reg <= cfg_data;
            end
            count_reg     <= count_next;
            committed_reg <= committed_next;
            pulse_reg     <= pulse_next;
            allconf_reg   <= allconf_next;
            status_reg    <= status_next;
            mask_reg      <= mask_next;
            done_reg      <= ctrl.report;
        end
    end

    // Capture the request beat and the result beat
    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            req_reg <= request;
        end
        if (ctrl.report)
        begin
            result_reg.status         <= status_reg;
            result_reg.entry_present  <= hit;
            result_reg.entry_state    <= hit ? rd_state : kct_pkg::ST_INITIAL;
            result_reg.retry_count    <= hit ? rd_retries : '0;
            result_reg.resend_mask    <= mask_reg;
            result_reg.just_committed <= pulse_reg;
            result_reg.node_count     <= count_reg;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

@@ sim/tb_key_confirmation_tracker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_confirmation_tracker_core: self-checking bench for the tracker core
// Drives add, remove, set, mark, response and sweep commands through the
// start/busy port and mirrors the node table in a local predictor. Every done
// beat is checked field by field against the oldest prediction. The run has
// several phases, each of which sets a retry limit and a sender gap rate.
// ----------------------------------------------------------------------------
module tb_key_confirmation_tracker_core;

    import kct_pkg::*;

    localparam int NODES        = MAX_NODES_DEFAULT;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 225;
    localparam int SETTLE_CYCLES = 24;
    localparam int PRINT_CAP    = 100;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    request_t             request = '0;
    logic                 done;
    result_t              result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [RETRY_W-1:0]   cfg_data = '0;

    // Commands waiting to be driven and results still owed by the block
    request_t             command_q[$];
    result_t              tracked_results[$];
    int unsigned          queued_items = 0;
    int unsigned          gap_pct = 0;
    int unsigned          mismatch_count = 0;
    int unsigned          beat_count = 0;

    // Mirror of the node table
    logic                 node_present [NODES];
    logic [STATE_W-1:0]   node_state   [NODES];
    logic [RETRY_W-1:0]   node_retries [NODES];
    logic [NONCE_W-1:0]   node_nonce   [NODES];
    logic                 commit_done;
    logic [RETRY_W-1:0]   retry_limit;

    key_confirmation_tracker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Clear one node table entry to all zeros
    function automatic void wipe_node(input int unsigned idx);
        node_present[idx] = 1'b0;
        node_state[idx]   = ST_INITIAL;
        node_retries[idx] = '0;
        node_nonce[idx]   = '0;
    endfunction

    // Apply one command to the mirror and return the result it should give
    function automatic result_t track_command(input request_t req);
        result_t     res;
        int unsigned id;
        int unsigned i;
        logic        all_received;
        logic [COUNT_W-1:0] count;

        res    = '0;
        id     = 32'(req.node_id);
        count  = '0;
        res.status = STAT_OK;
        case (req.command)
            CMD_ADD:
            begin
                wipe_node(id);
                node_present[id] = 1'b1;
            end
            CMD_REMOVE:
                wipe_node(id);
            CMD_SET:
            begin
                if (!node_present[id])
                    res.status = STAT_NOT_FOUND;
                else
                    node_state[id] = req.new_state;
            end
            CMD_MARK:
            begin
                if (!node_present[id])
                    res.status = STAT_NOT_FOUND;
                else
                    node_state[id] = ST_WAITING;
            end
            CMD_RESPONSE:
            begin
                // Reject in order: absent, not awaiting, bad tag, stale nonce
                if (!node_present[id])
                    res.status = STAT_NOT_FOUND;
                else if (node_state[id] != ST_WAITING && node_state[id] != ST_RESENT)
                    res.status = STAT_NOT_AWAITING;
                else if (!req.tag_valid)
                    res.status = STAT_TAG_REJECTED;
                else if (req.nonce_count <= node_nonce[id])
                    res.status = STAT_REPLAY;
                else
                begin
                    node_nonce[id] = req.nonce_count;
                    node_state[id] = ST_RECEIVED;
                    all_received = 1'b1;
                    for (i = 0; i < NODES; i++)
                        if (node_present[i] && node_state[i] != ST_RECEIVED)
                            all_received = 1'b0;
                    if (!commit_done && all_received)
                    begin
                        commit_done = 1'b1;
                        res.just_committed = 1'b1;
                    end
                end
            end
            CMD_SWEEP:
            begin
                // Bump awaiting nodes still below the limit and flag them
                for (i = 0; i < NODES; i++)
                begin
                    if (node_present[i] && node_retries[i] < retry_limit &&
                        (node_state[i] == ST_WAITING || node_state[i] == ST_RESENT))
                    begin
                        node_retries[i] = node_retries[i] + 1'b1;
                        node_state[i]   = ST_RESENT;
                        res.resend_mask[i] = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        for (i = 0; i < NODES; i++)
            count = count + COUNT_W'(node_present[i]);
        res.node_count = count;
        if (node_present[id])
        begin
            res.entry_present = 1'b1;
            res.entry_state   = node_state[id];
            res.retry_count   = node_retries[id];
        end
        return res;
    endfunction

    // Report one mismatch; keep counting once the print cap is reached
    task automatic flag_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("beat %0d %s got %0h want %0h",
                                    beat_count, name, got, want));
    endtask

    // Driver: present the next queued command, hold it until taken
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
                tracked_results = {tracked_results, track_command(request)};
            if (!start || !busy)
            begin
                if (command_q.size() != 0 && $urandom_range(99) >= gap_pct)
                begin
                    start   <= 1'b1;
                    request <= command_q.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: check every done beat against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (tracked_results.size() == 0)
                flag_mismatch($sformatf("beat %0d with no result outstanding", beat_count));
            else
            begin
                want = tracked_results.pop_front();
                compare_field("status", 32'(result.status), 32'(want.status));
                compare_field("entry_present", 32'(result.entry_present),
                              32'(want.entry_present));
                compare_field("entry_state", 32'(result.entry_state),
                              32'(want.entry_state));
                compare_field("retry_count", 32'(result.retry_count),
                              32'(want.retry_count));
                compare_field("resend_mask", 32'(result.resend_mask),
                              32'(want.resend_mask));
                compare_field("just_committed", 32'(result.just_committed),
                              32'(want.just_committed));
                compare_field("node_count", 32'(result.node_count),
                              32'(want.node_count));
            end
            beat_count++;
        end
    end

    function automatic logic [NONCE_W-1:0] rand_nonce();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int unsigned id,
                             input logic [STATE_W-1:0] nst, input logic tag,
                             input logic [NONCE_W-1:0] nonce);
        request_t req;
        req.command     = cmd;
        req.node_id     = id[NODE_ID_W-1:0];
        req.new_state   = nst;
        req.tag_valid   = tag;
        req.nonce_count = nonce;
        command_q = {command_q, req};
        queued_items++;
    endtask

    // Fully random commands, unused codes included
    task automatic queue_noise(input int unsigned n);
        int unsigned k;
        for (k = 0; k < n; k++)
            queue_cmd(CMD_W'($urandom_range(7)), $urandom_range(15),
                      STATE_W'($urandom_range(3)), 1'($urandom_range(1)), rand_nonce());
    endtask

    // Edge cases from reset: nodes 1 to 10 present, all initial
    task automatic queue_directed();
        queue_cmd(CMD_RESPONSE, 0, ST_INITIAL, 1'b1, 64'd7);
        queue_cmd(CMD_SET, 0, ST_WAITING, 1'b0, '0);
        queue_cmd(CMD_MARK, 12, ST_INITIAL, 1'b0, '0);
        queue_cmd(CMD_RESPONSE, 1, ST_INITIAL, 1'b1, 64'd5);
        queue_cmd(CMD_MARK, 1, ST_RESENT, 1'b1, '1);
        queue_cmd(CMD_RESPONSE, 1, ST_INITIAL, 1'b0, 64'd5);
        queue_cmd(CMD_RESPONSE, 1, ST_INITIAL, 1'b1, 64'd0);
        queue_cmd(CMD_RESPONSE, 1, ST_RESENT, 1'b1, '1);
        queue_cmd(CMD_SET, 1, ST_WAITING, 1'b0, '0);
        queue_cmd(CMD_RESPONSE, 1, ST_INITIAL, 1'b1, '1);
        queue_cmd(CMD_SET, 2, ST_RESENT, 1'b0, '0);
        queue_cmd(CMD_SET, 3, ST_RECEIVED, 1'b0, '0);
        queue_cmd(CMD_SET, 4, ST_INITIAL, 1'b1, '1);
        queue_cmd(CMD_SET, 1, ST_WAITING, 1'b0, '0);
        queue_cmd(CMD_SWEEP, 2, ST_INITIAL, 1'b0, '0);
        queue_cmd(CMD_SWEEP, 1, ST_RESENT, 1'b1, '1);
        queue_cmd(CMD_SWEEP, 15, ST_INITIAL, 1'b0, '0);
        queue_cmd(CMD_ADD, 15, ST_RESENT, 1'b1, '1);
        queue_cmd(CMD_ADD, 0, ST_INITIAL, 1'b0, '0);
        queue_cmd(CMD_ADD, 2, ST_INITIAL, 1'b0, '0);
        queue_cmd(CMD_REMOVE, 15, ST_INITIAL, 1'b0, '0);
        queue_cmd(CMD_REMOVE, 15, ST_RESENT, 1'b1, '1);
        queue_cmd(3'd6, 3, ST_WAITING, 1'b1, '1);
        queue_cmd(3'd7, 15, ST_RESENT, 1'b0, '0);
    endtask

    // Full confirmation round: rebuild membership, arm, then answer each node
    task automatic queue_round();
        logic               member [NODES];
        int unsigned        share;
        int unsigned        base;
        int unsigned        i;
        int unsigned        j;
        logic [NONCE_W-1:0] n;

        share = $urandom_range(100);
        for (i = 0; i < NODES; i++)
        begin
            member[i] = ($urandom_range(99) < share);
            queue_cmd(member[i] ? CMD_ADD : CMD_REMOVE, i, STATE_W'($urandom_range(3)),
                      1'($urandom_range(1)), rand_nonce());
        end
        for (i = 0; i < NODES; i++)
        begin
            if (!member[i])
                continue;
            if ($urandom_range(3) == 0)
                queue_cmd(CMD_SET, i, $urandom_range(1) ? ST_WAITING : ST_RESENT,
                          1'($urandom_range(1)), rand_nonce());
            else
                queue_cmd(CMD_MARK, i, STATE_W'($urandom_range(3)), 1'($urandom_range(1)),
                          rand_nonce());
        end
        if ($urandom_range(3) == 0)
            queue_cmd(CMD_SWEEP, $urandom_range(15), STATE_W'($urandom_range(3)),
                      1'($urandom_range(1)), rand_nonce());
        base = $urandom_range(15);
        for (j = 0; j < NODES; j++)
        begin
            i = (base + j) % NODES;
            if ($urandom_range(9) == 0)
                queue_noise(1);
            if (!member[i])
                continue;
            case ($urandom_range(7))
                0: queue_cmd(CMD_RESPONSE, i, STATE_W'($urandom_range(3)), 1'b0,
                             rand_nonce());
                1: queue_cmd(CMD_RESPONSE, i, STATE_W'($urandom_range(3)), 1'b1, '0);
                default: ;
            endcase
            // Keep headroom so a later fresher nonce exists
            n = rand_nonce();
            n[NONCE_W-1] = 1'b0;
            if (n == '0)
                n = 64'd1;
            queue_cmd(CMD_RESPONSE, i, STATE_W'($urandom_range(3)), 1'b1, n);
            if ($urandom_range(5) == 0)
            begin
                queue_cmd(CMD_MARK, i, STATE_W'($urandom_range(3)), 1'($urandom_range(1)),
                          rand_nonce());
                queue_cmd(CMD_RESPONSE, i, STATE_W'($urandom_range(3)), 1'b1, n);
                n[NONCE_W-1] = 1'b1;
                queue_cmd(CMD_RESPONSE, i, STATE_W'($urandom_range(3)), 1'b1, n);
            end
        end
    endtask

    // Arm a few nodes and sweep repeatedly to push retries to the limit
    task automatic queue_sweeps();
        int unsigned k;
        for (k = 0; k < 1 + $urandom_range(4); k++)
            queue_cmd(CMD_MARK, $urandom_range(15), STATE_W'($urandom_range(3)),
                      1'($urandom_range(1)), rand_nonce());
        for (k = 0; k < 1 + $urandom_range(5); k++)
            queue_cmd(CMD_SWEEP, $urandom_range(15), STATE_W'($urandom_range(3)),
                      1'($urandom_range(1)), rand_nonce());
        for (k = 0; k < $urandom_range(3); k++)
            queue_cmd(CMD_RESPONSE, $urandom_range(15), STATE_W'($urandom_range(3)),
                      1'($urandom_range(1)), rand_nonce());
    endtask

    task automatic write_retry_limit(input logic [RETRY_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        retry_limit = value;
    endtask

    // Wait until every command is taken and every result has come back
    task automatic drain();
        while (command_q.size() != 0 || start || busy || tracked_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [RETRY_W-1:0] limits [PHASES];
        int unsigned        gaps   [PHASES];
        int unsigned        p;
        int unsigned        i;
        int unsigned        phase_base;
        int unsigned        pick;

        // Reset state of the mirror
        for (i = 0; i < NODES; i++)
        begin
            wipe_node(i);
            node_present[i] = (i >= 1 && i <= DEFAULT_NODES);
        end
        commit_done = 1'b0;
        retry_limit = MAX_RETRY_RESET;

        limits[0] = 8'd2;   gaps[0] = 0;
        limits[1] = 8'd0;   gaps[1] = 55;
        limits[2] = 8'd255; gaps[2] = 29;
        limits[3] = 8'd1;   gaps[3] = 0;
        limits[4] = RETRY_W'($urandom_range(255)); gaps[4] = 55;
        limits[5] = 8'd3;   gaps[5] = 29;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (p = 0; p < PHASES; p++)
        begin
            write_retry_limit(limits[p]);
            gap_pct = gaps[p];
            if (p == 0)
                queue_directed();
            phase_base = queued_items;
            while (queued_items - phase_base < PHASE_ITEMS)
            begin
                pick = $urandom_range(9);
                if (pick < 6)
                    queue_round();
                else if (pick < 8)
                    queue_sweeps();
                else
                    queue_noise(1 + $urandom_range(3));
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: several times the slowest expected run
    initial
    begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/kct_pkg.sv
rtl/kct_ctrl.sv
rtl/kct_datapath.sv
rtl/key_confirmation_tracker_core.sv
sim/tb_key_confirmation_tracker_core.sv
